/* hw/rtl/mfp_pkg.sv */
// Shared types and constants for the motor feedback frame parser.
// Holds frame layout, CRC-32 column table and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package mfp_pkg;

    localparam int CRC_WORDS  = 18;
    localparam int CRC_OFFSET = 74;

    localparam logic [6:0] FRAME_LEN  = 7'(CRC_OFFSET + 4);
    localparam logic [6:0] LAST_POS   = 7'(CRC_OFFSET + 3);
    localparam logic [6:0] DATA_LEN   = 7'(4 * CRC_WORDS);
    localparam logic [6:0] CRC_POS    = 7'(CRC_OFFSET);

    localparam logic [6:0] POS_ID        = 7'd2;
    localparam logic [6:0] POS_MODE      = 7'd4;
    localparam logic [6:0] POS_TEMP      = 7'd6;
    localparam logic [6:0] POS_FAULT     = 7'd7;
    localparam logic [6:0] POS_TORQUE_LO = 7'd12;
    localparam logic [6:0] POS_TORQUE_HI = 7'd13;
    localparam logic [6:0] POS_SPEED_LO  = 7'd14;
    localparam logic [6:0] POS_SPEED_HI  = 7'd15;
    localparam logic [6:0] POS_POSITION  = 7'd30;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef logic [31:0][31:0] crc_cols_t;

    // Column i is the CRC of a single set bit i after a full word of shifts.
    function automatic crc_cols_t crc_cols_calc();
        crc_cols_t cols;
        logic [31:0] v;
        logic        top;
        for (int i = 0; i < 32; i++)
        begin
            v = 32'h1 << i;
            for (int s = 0; s < 32; s++)
            begin
                top = v[31];
                v   = v << 1;
                if (top)
                begin
                    v = v ^ CRC_POLY;
                end
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_cols_calc();

    // Fold one word into the CRC: linear map of crc xor word.
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] d;
        logic [31:0] acc;
        d   = crc ^ word;
        acc = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (d[i])
            begin
                acc = acc ^ CRC_COLS[i];
            end
        end
        return acc;
    endfunction

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] pos;
        logic       start;
        logic       last;
    } entry_t;

endpackage

/* hw/rtl/mfp_if.sv */
// Channel interfaces for the motor feedback frame parser.
// Byte input channel and result output channel; no dependencies.
`timescale 1ns / 1ps

interface mfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface mfp_out_if;
    logic               valid;
    logic               ready;
    logic               crc_ok;
    logic        [7:0]  motor_id;
    logic        [7:0]  motor_mode;
    logic        [7:0]  temperature;
    logic        [7:0]  fault_code;
    logic signed [15:0] torque_raw;
    logic signed [15:0] speed_raw;
    logic signed [31:0] position_raw;

    modport source (output valid, crc_ok, motor_id, motor_mode, temperature, fault_code,
                    torque_raw, speed_raw, position_raw, input ready);
    modport sink   (input valid, crc_ok, motor_id, motor_mode, temperature, fault_code,
                    torque_raw, speed_raw, position_raw, output ready);
endinterface

/* hw/rtl/mfp_front.sv */
// Front end: accepts bytes, tracks frame position, drops idle bytes.
// Depends on mfp_pkg and mfp_in_if.
`timescale 1ns / 1ps

module mfp_front
(
    input  logic          clk,
    input  logic          rst_n,
    mfp_in_if.sink        rx,
    output logic          push_valid,
    output mfp_pkg::entry_t push_entry,
    input  logic          push_ready
);

    logic [6:0] pos_reg;
    logic [6:0] pos_next;
    logic       in_frame;

    assign rx.ready = push_ready;

    always_comb
    begin
        in_frame            = pos_reg < mfp_pkg::FRAME_LEN;
        push_entry.data     = rx.rx_byte;
        push_entry.start    = rx.frame_start;
        push_entry.pos      = rx.frame_start ? 7'd0 : pos_reg;
        push_entry.last     = push_entry.pos == mfp_pkg::LAST_POS;
        push_valid          = rx.valid && (rx.frame_start || in_frame);
        pos_next            = pos_reg;
        if (rx.valid && push_ready)
        begin
            if (rx.frame_start || in_frame)
            begin
                pos_next = push_entry.pos + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= mfp_pkg::FRAME_LEN;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* hw/rtl/mfp_queue.sv */
// Short queue between front and back end.
// Depends on mfp_pkg.
`timescale 1ns / 1ps

module mfp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  mfp_pkg::entry_t push_entry,
    output logic            push_ready,
    output logic            pop_valid,
    output mfp_pkg::entry_t pop_entry,
    input  logic            pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfp_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        push_ready  = count_reg != CNT_W'(DEPTH);
        pop_valid   = count_reg != '0;
        pop_entry   = slot_reg[rd_ptr_reg];
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hw/rtl/mfp_back.sv */
// Back end: CRC word update, field capture and result register.
// Depends on mfp_pkg and mfp_out_if.
`timescale 1ns / 1ps

module mfp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  mfp_pkg::entry_t q_entry,
    output logic            q_pop,
    mfp_out_if.source       res
);

    logic        [31:0] crc_reg;
    logic        [31:0] crc_next;
    logic        [23:0] gather_reg;
    logic        [23:0] gather_next;
    logic        [31:0] expected_reg;
    logic        [31:0] expected_next;
    logic        [7:0]  id_reg;
    logic        [7:0]  id_next;
    logic        [7:0]  mode_reg;
    logic        [7:0]  mode_next;
    logic        [7:0]  temp_reg;
    logic        [7:0]  temp_next;
    logic        [7:0]  fault_reg;
    logic        [7:0]  fault_next;
    logic        [15:0] torque_reg;
    logic        [15:0] torque_next;
    logic        [15:0] speed_reg;
    logic        [15:0] speed_next;
    logic        [31:0] position_reg;
    logic        [31:0] position_next;

    logic               out_valid_reg;
    logic               ok_reg;
    logic        [7:0]  out_id_reg;
    logic        [7:0]  out_mode_reg;
    logic        [7:0]  out_temp_reg;
    logic        [7:0]  out_fault_reg;
    logic signed [15:0] out_torque_reg;
    logic signed [15:0] out_speed_reg;
    logic signed [31:0] out_position_reg;

    logic        [31:0] crc_base;
    logic        [23:0] gather_base;
    logic        [6:0]  crc_off;
    logic        [6:0]  pos_off;
    logic        [7:0]  b;
    logic               out_free;
    logic               ok;

    always_comb
    begin
        out_free = !out_valid_reg || res.ready;
        q_pop    = q_valid && (!q_entry.last || out_free);
        b        = q_entry.data;
        crc_base    = q_entry.start ? mfp_pkg::CRC_INIT : crc_reg;
        gather_base = q_entry.start ? 24'd0 : gather_reg;
        crc_next    = crc_base;
        gather_next = gather_base;
        expected_next = expected_reg;
        id_next       = id_reg;
        mode_next     = mode_reg;
        temp_next     = temp_reg;
        fault_next    = fault_reg;
        torque_next   = torque_reg;
        speed_next    = speed_reg;
        position_next = position_reg;
        crc_off = q_entry.pos - mfp_pkg::CRC_POS;
        pos_off = q_entry.pos - mfp_pkg::POS_POSITION;

        if (q_entry.pos < mfp_pkg::DATA_LEN)
        begin
            case (q_entry.pos[1:0])
                2'd0: gather_next[7:0]   = b;
                2'd1: gather_next[15:8]  = b;
                2'd2: gather_next[23:16] = b;
                default:
                begin
                    crc_next    = mfp_pkg::crc_word(crc_base, {b, gather_base});
                    gather_next = 24'd0;
                end
            endcase
        end

        case (q_entry.pos)
            mfp_pkg::POS_ID:        id_next            = b;
            mfp_pkg::POS_MODE:      mode_next          = b;
            mfp_pkg::POS_TEMP:      temp_next          = b;
            mfp_pkg::POS_FAULT:     fault_next         = b;
            mfp_pkg::POS_TORQUE_LO: torque_next[7:0]   = b;
            mfp_pkg::POS_TORQUE_HI: torque_next[15:8]  = b;
            mfp_pkg::POS_SPEED_LO:  speed_next[7:0]    = b;
            mfp_pkg::POS_SPEED_HI:  speed_next[15:8]   = b;
            default: ;
        endcase

        if (q_entry.pos >= mfp_pkg::POS_POSITION && pos_off < 7'd4)
        begin
            case (pos_off[1:0])
                2'd0:    position_next[7:0]   = b;
                2'd1:    position_next[15:8]  = b;
                2'd2:    position_next[23:16] = b;
                default: position_next[31:24] = b;
            endcase
        end

        if (q_entry.pos >= mfp_pkg::CRC_POS && q_entry.pos < mfp_pkg::FRAME_LEN)
        begin
            case (crc_off[1:0])
                2'd0:    expected_next[7:0]   = b;
                2'd1:    expected_next[15:8]  = b;
                2'd2:    expected_next[23:16] = b;
                default: expected_next[31:24] = b;
            endcase
        end

        ok = expected_next == crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= mfp_pkg::CRC_INIT;
            gather_reg   <= '0;
            expected_reg <= '0;
            id_reg       <= '0;
            mode_reg     <= '0;
            temp_reg     <= '0;
            fault_reg    <= '0;
            torque_reg   <= '0;
            speed_reg    <= '0;
            position_reg <= '0;
        end
        else if (q_pop)
        begin
            crc_reg      <= crc_next;
            gather_reg   <= gather_next;
            expected_reg <= expected_next;
            id_reg       <= id_next;
            mode_reg     <= mode_next;
            temp_reg     <= temp_next;
            fault_reg    <= fault_next;
            torque_reg   <= torque_next;
            speed_reg    <= speed_next;
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_entry.last)
        begin
            ok_reg           <= ok;
            out_id_reg       <= ok ? id_next : 8'd0;
            out_mode_reg     <= ok ? mode_next : 8'd0;
            out_temp_reg     <= ok ? temp_next : 8'd0;
            out_fault_reg    <= ok ? fault_next : 8'd0;
            out_torque_reg   <= ok ? torque_next : 16'd0;
            out_speed_reg    <= ok ? speed_next : 16'd0;
            out_position_reg <= ok ? position_next : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop && q_entry.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.crc_ok       = ok_reg;
    assign res.motor_id     = out_id_reg;
    assign res.motor_mode   = out_mode_reg;
    assign res.temperature  = out_temp_reg;
    assign res.fault_code   = out_fault_reg;
    assign res.torque_raw   = out_torque_reg;
    assign res.speed_raw    = out_speed_reg;
    assign res.position_raw = out_position_reg;

endmodule

/* hw/rtl/motor_feedback_frame_parser_core.sv */
// Motor feedback frame parser, top level.
// Depends on mfp_pkg, mfp_if, mfp_front, mfp_queue and mfp_back.
//
// Usage:
//   rx  : one frame byte per word (rx_byte, frame_start). frame_start marks
//         byte 0 and restarts the frame; bytes outside a frame are taken and
//         dropped.
//   res : one word per complete 78-byte frame: crc_ok and the decoded
//         fields, all fields zero when the CRC fails.
//   Throughput is one byte per cycle while the queue has room. Each byte
//   passes the front end in the cycle it is taken, is registered in the
//   queue, and the back end folds it when it pops it: a CRC-32 word update
//   on every fourth data byte through a single XOR matrix. res.valid rises
//   in the cycle after the back end pops the last CRC byte.
//   Reset leaves the parser idle until the next frame_start and empties the
//   queue and result register.
//   When res stalls, the back end holds the last byte of the next frame; the
//   QUEUE_DEPTH-entry queue fills and then rx.ready drops.
`timescale 1ns / 1ps

module motor_feedback_frame_parser_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    mfp_in_if.sink    rx,
    mfp_out_if.source res
);

    logic            push_valid;
    logic            push_ready;
    mfp_pkg::entry_t push_entry;
    logic            pop_valid;
    logic            pop_ready;
    mfp_pkg::entry_t pop_entry;

    mfp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    mfp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    mfp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_entry (pop_entry),
        .q_pop   (pop_ready),
        .res     (res)
    );

endmodule
